FILE: rtl/tlr_pkg.sv
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared widths, constants and side-band type for the TOF LOR pipeline.
// ----------------------------------------------------------------------------
package tlr_pkg;

	localparam int POS_W   = 19;              // hit / center coordinate
	localparam int TIME_W  = 20;              // hit time
	localparam int CHORD_W = POS_W + 1;       // first - second, first + second
	localparam int DT_W    = TIME_W + 1;
	localparam int DIR_W   = 16;              // Q1.15
	localparam int LS_W    = 24;              // light speed, Q0.24
	localparam int SUMSQ_W = 2 * CHORD_W;     // sum of three squares < 2^40
	localparam int RAD_W   = SUMSQ_W + 16;    // radicand S * 2^16
	localparam int ROOT_W  = RAD_W / 2;       // |c| in Q.8
	localparam int ACC_W   = RAD_W + 1;
	localparam int Q_W     = DIR_W;           // quotient bits, <= 2^15
	localparam int NUM_W   = CHORD_W + 23 + 1; // |c|*2^23 + L/2

	localparam logic [LS_W-1:0] LS_RESET = 24'd502969;

	typedef struct packed {
		logic [2:0][CHORD_W-1:0] c;    // chord, signed per axis
		logic [2:0][CHORD_W-1:0] sum;  // first + second, signed per axis
		logic [DT_W-1:0]         dt;   // second_time - first_time, signed
		logic                    degen;
	} side_t;

endpackage

FILE: rtl/tlr_sqrt.sv
// ----------------------------------------------------------------------------
// tlr_sqrt
// Pipelined integer square root, one result bit per stage, side-band carried.
// ----------------------------------------------------------------------------
module tlr_sqrt import tlr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  in_rad,
	input  side_t             in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output side_t             out_side
);

	logic [RAD_W-1:0] rem_s  [0:ROOT_W];
	logic [ACC_W-1:0] acc_s  [0:ROOT_W];
	side_t            side_s [0:ROOT_W];
	logic [ROOT_W:0]  vld_s;

	assign rem_s[0]  = in_rad;
	assign acc_s[0]  = '0;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (RAD_W - 2 - 2 * k);
		logic [ACC_W-1:0] trial;
		logic             ge;

		assign trial = acc_s[k] + BIT;
		assign ge    = {1'b0, rem_s[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? rem_s[k] - trial[RAD_W-1:0] : rem_s[k];
				acc_s[k+1]  <= ge ? (acc_s[k] >> 1) + BIT : acc_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W];
	assign out_root = acc_s[ROOT_W][ROOT_W-1:0];
	assign out_side = side_s[ROOT_W];

endmodule

FILE: rtl/tlr_div.sv
// ----------------------------------------------------------------------------
// tlr_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tlr_div import tlr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic [2:0][NUM_W-1:0]   in_num,
	input  logic [ROOT_W-1:0]       in_den,
	input  side_t                   in_side,
	output logic                    out_vld,
	output logic [2:0][Q_W-1:0]     out_quo,
	output side_t                   out_side
);

	logic [2:0][NUM_W-1:0] rem_s  [0:Q_W];
	logic [2:0][Q_W-1:0]   quo_s  [0:Q_W];
	logic [ROOT_W-1:0]     den_s  [0:Q_W];
	side_t                 side_s [0:Q_W];
	logic [Q_W:0]          vld_s;

	assign rem_s[0]  = in_num;
	assign quo_s[0]  = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [NUM_W-1:0] dsh;
		logic [2:0]       ge;

		assign dsh = NUM_W'(den_s[k]) << (Q_W - 1 - k);
		for (genvar j = 0; j < 3; j++) begin : g_lane
			assign ge[j] = rem_s[k][j] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					rem_s[k+1][j] <= ge[j] ? rem_s[k][j] - dsh : rem_s[k][j];
					quo_s[k+1][j] <= {quo_s[k][j][Q_W-2:0], ge[j]};
				end
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[Q_W];
	assign out_quo  = quo_s[Q_W];
	assign out_side = side_s[Q_W];

endmodule

FILE: rtl/tof_lor_reconstruct_unit.sv
// ----------------------------------------------------------------------------
// tof_lor_reconstruct_unit
// TOF line-of-response: unit chord direction and estimated annihilation point.
// ----------------------------------------------------------------------------
// Pipeline: 28 square-root stages, 16 divider stages, 8 arithmetic and output
// stages, from input beat to output beat.
// Throughput: one coincidence per cycle; the whole pipeline stalls together
// while the output register holds an untaken beat.
// Reset: arst_n clears all valid bits; light_speed returns to 502969.
// ----------------------------------------------------------------------------
module tof_lor_reconstruct_unit import tlr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             light_speed_we,
	input  logic [LS_W-1:0]  light_speed_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// first_x, first_y, first_z, first_time, second_x, second_y, second_z, second_time
	input  logic [159:0]     s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// center_x, center_y, center_z, dir_x, dir_y, dir_z
	output logic [111:0]     m_axis_tdata,
	// degenerate
	output logic [0:0]       m_axis_tuser
);

	logic [LS_W-1:0] light_speed_q;
	logic            en;
	logic            out_vld_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) light_speed_q <= LS_RESET;
		else if (light_speed_we) light_speed_q <= light_speed_wdata;
	end

	// input fields
	logic signed [POS_W-1:0]  fa [3];
	logic signed [POS_W-1:0]  fb [3];
	logic signed [TIME_W-1:0] ta, tb;

	assign fa[0] = s_axis_tdata[18:0];
	assign fa[1] = s_axis_tdata[37:19];
	assign fa[2] = s_axis_tdata[56:38];
	assign ta    = s_axis_tdata[76:57];
	assign fb[0] = s_axis_tdata[95:77];
	assign fb[1] = s_axis_tdata[114:96];
	assign fb[2] = s_axis_tdata[133:115];
	assign tb    = s_axis_tdata[153:134];

	// stage 1: chord, midpoint sum, time difference
	side_t side_s1;
	logic  vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				side_s1.c[i]   <= CHORD_W'(fa[i]) - CHORD_W'(fb[i]);
				side_s1.sum[i] <= CHORD_W'(fa[i]) + CHORD_W'(fb[i]);
			end
			side_s1.dt    <= DT_W'(tb) - DT_W'(ta);
			side_s1.degen <= 1'b0;
		end
	end

	// stage 2: squares
	side_t                      side_s2;
	logic                       vld_s2;
	logic [2:0][SUMSQ_W-1:0]    sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= SUMSQ_W'($signed(side_s1.c[i]) * $signed(side_s1.c[i]));
			side_s2 <= side_s1;
		end
	end

	// stage 3: sum of squares, coincidence flag
	side_t              side_s3;
	logic               vld_s3;
	logic [SUMSQ_W-1:0] ssq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ssq_s3        <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3.c     <= side_s2.c;
			side_s3.sum   <= side_s2.sum;
			side_s3.dt    <= side_s2.dt;
			side_s3.degen <= (side_s2.c == '0);
		end
	end

	// square root of S * 2^16
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	tlr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_rad   ({ssq_s3, 16'd0}),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// stage 4: dividend |c| * 2^23 + L / 2
	side_t                 side_s4;
	logic                  vld_s4;
	logic [2:0][NUM_W-1:0] num_s4;
	logic [ROOT_W-1:0]     den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		logic [CHORD_W-1:0] mag;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag       = sq_side.c[i][CHORD_W-1] ? -sq_side.c[i] : sq_side.c[i];
				num_s4[i] <= (NUM_W'(mag) << 23) + NUM_W'(sq_root >> 1);
			end
			den_s4  <= sq_root;
			side_s4 <= sq_side;
		end
	end

	logic                dv_vld;
	logic [2:0][Q_W-1:0] dv_quo;
	side_t               dv_side;

	tlr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_num   (num_s4),
		.in_den   (den_s4),
		.in_side  (side_s4),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// stage 5: sign and clamp of the direction, zero for a degenerate chord
	side_t                 side_s5;
	logic                  vld_s5;
	logic [2:0][DIR_W-1:0] dir_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_side.degen)
					dir_s5[i] <= '0;
				else if (dv_side.c[i][CHORD_W-1])
					dir_s5[i] <= -dv_quo[i];
				else if (dv_quo[i][Q_W-1])
					dir_s5[i] <= {1'b0, {(DIR_W-1){1'b1}}};
				else
					dir_s5[i] <= dv_quo[i];
			end
			side_s5 <= dv_side;
		end
	end

	// stage 6: dir * light_speed
	localparam int P_W = DIR_W + LS_W;
	localparam int M_W = P_W + DT_W;
	localparam int T_W = M_W + 1;

	side_t                 side_s6;
	logic                  vld_s6;
	logic [2:0][DIR_W-1:0] dir_s6;
	logic [2:0][P_W-1:0]   p_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (en) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				p_s6[i] <= P_W'($signed(dir_s5[i]) * $signed({1'b0, light_speed_q}));
			dir_s6  <= dir_s5;
			side_s6 <= side_s5;
		end
	end

	// stage 7: times dt
	side_t                 side_s7;
	logic                  vld_s7;
	logic [2:0][DIR_W-1:0] dir_s7;
	logic [2:0][M_W-1:0]   m_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (en) vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				m_s7[i] <= M_W'($signed(p_s6[i]) * $signed(side_s6.dt));
			dir_s7  <= dir_s6;
			side_s7 <= side_s6;
		end
	end

	// output stage: add midpoint, round half away from zero, saturate
	logic [2:0][POS_W-1:0] ctr_q;
	logic [2:0][DIR_W-1:0] dir_q;
	logic                  degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_s7;
	end

	always_ff @(posedge clk) begin
		logic signed [T_W-1:0] t;
		logic [T_W-1:0]        mag;
		logic [T_W-31:0]       q;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t   = (T_W'($signed(side_s7.sum[i])) <<< 29) + T_W'($signed(m_s7[i]));
				mag = t[T_W-1] ? -t : t;
				q   = (T_W-30)'((mag + (T_W'(1) << 29)) >> 30);
				if (t[T_W-1])
					ctr_q[i] <= (q > (T_W-30)'(262144)) ? {1'b1, {(POS_W-1){1'b0}}}
						: POS_W'(-q);
				else
					ctr_q[i] <= (q > (T_W-30)'(262143)) ? {1'b0, {(POS_W-1){1'b1}}}
						: POS_W'(q);
			end
			dir_q   <= dir_s7;
			degen_q <= side_s7.degen;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, dir_q[2], dir_q[1], dir_q[0], ctr_q[2], ctr_q[1], ctr_q[0]};
	assign m_axis_tuser  = degen_q;

	// coincident hits never give a direction
	a_degen_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && degen_q |-> dir_q == '0)
		else $error("degenerate beat with nonzero direction");

	// a held output beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !m_axis_tready |=> out_vld_q && $stable(ctr_q) && $stable(dir_q))
		else $error("stalled output beat changed");

	// chord of zero length flagged exactly at the sum-of-squares stage
	a_degen_ssq: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> side_s3.degen == (ssq_s3 == '0))
		else $error("degenerate flag disagrees with chord length");

endmodule
